// File: design/assert_macros.svh
// Assertion helpers for the parser top level, which checks its own logic.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/crp_pkg.sv
`default_nettype none
package crp_pkg;

  // Default depth of the hold buffer.
  localparam int HOLD_DEPTH_DEF = 16;

  // Beat widths on the two streams, and the accumulator width.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;
  localparam int ACC_W      = 16;

  // Bytes of the cursor report pattern.
  localparam logic [7:0] BYTE_ESC      = 8'h1b;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5b;
  localparam logic [7:0] BYTE_SEMI     = 8'h3b;
  localparam logic [7:0] BYTE_R        = 8'h52;
  localparam logic [7:0] BYTE_ZERO     = 8'h30;
  localparam logic [7:0] BYTE_NINE     = 8'h39;

  // Input command carried in the input tuser.
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // Result kind carried in the output tuser.
  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // input beat accepted this cycle
    logic rd_issue;  // read the held byte at the flush index
    logic send;      // load the read byte into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a new result
    logic flush_go;    // the offered input starts a flush
    logic flush_last;  // flush index points at the final held byte
  } dp_status_t;

endpackage
`default_nettype wire

// File: design/cursor_report_parser.sv
// Cursor report parser. Terminal bytes come in on the s_ stream, one per beat,
// with s_tuser low; a beat with s_tuser high is a timeout that flushes held bytes.
// Results leave on the m_ stream: m_tuser gives the kind (key, report, rejected
// report), m_tdata carries the key byte and the row and column counts, and
// m_tlast marks the final result caused by one input beat.
// A plain key byte, or the 'R' closing a report, gives its single result in the
// cycle after it is accepted, so with a ready receiver one byte per cycle is sustained.
// A byte that breaks the pattern, a full hold buffer or a timeout flushes the
// held bytes: each one is read from the hold buffer and then loaded into the
// output register, and input is not accepted until the flush is done.
// Bytes that only extend a report give no result and do not hold up input.
// The output register lets a new input beat in during the cycle its result drains.
// When the receiver stalls, the output register holds and input is refused.
// Reset clears the collection state and the output valid flag; the hold buffer
// needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module cursor_report_parser #(
  parameter int HOLD_DEPTH = crp_pkg::HOLD_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [crp_pkg::IN_DATA_W-1:0]  s_tdata,   // in_byte[7:0]
  input  wire logic                           s_tuser,   // cmd[0]
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [crp_pkg::OUT_DATA_W-1:0]      m_tdata,   // key_byte[7:0], report_rows[23:8],
                                                         // report_cols[39:24]
  output logic [1:0]                          m_tuser,   // kind[1:0]
  output logic                                m_tlast    // last
);
  import crp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer for input acceptance and flushing.
  crp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // Pattern matching, accumulators, hold buffer and output register.
  crp_datapath #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .cmd     (cmd),
    .status  (status)
  );

  // A flushed byte is only loaded when the output register is free.
  `ASSERT_SAME(a_send_free, clk, rst, cmd.send, status.out_free)
  // No input is taken while the hold buffer is being read out.
  `ASSERT_SAME(a_no_take_in_flush, clk, rst, cmd.rd_issue, !s_tready)
  // A read of the hold buffer is always followed by a send attempt, never a take.
  `ASSERT_NEXT(a_read_then_send, clk, rst, cmd.rd_issue, !cmd.take)
  // Accepted reports carry nonzero counts.
  `ASSERT_SAME(a_report_nonzero, clk, rst, m_tvalid && (m_tuser == KIND_REPORT),
               (m_tdata[23:8] != '0) && (m_tdata[39:24] != '0))
  // Keys and rejected reports carry no counts.
  `ASSERT_SAME(a_no_counts, clk, rst, m_tvalid && (m_tuser != KIND_REPORT),
               m_tdata[39:8] == '0)

endmodule
`default_nettype wire

// File: design/crp_ram.sv
`default_nettype none
module crp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/crp_ctrl.sv
`default_nettype none
module crp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire crp_pkg::dp_status_t status,
  output crp_pkg::dp_cmd_t         cmd
);
  import crp_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.send     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = status.out_free;
        cmd.take = s_tvalid && status.out_free;
        if (cmd.take && status.flush_go) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_SEND;
      end
      ST_SEND: begin
        if (status.out_free) begin
          cmd.send   = 1'b1;
          state_next = status.flush_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/crp_datapath.sv
`default_nettype none
module crp_datapath #(
  parameter int HOLD_DEPTH = crp_pkg::HOLD_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [crp_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [crp_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [1:0]                         m_tuser,
  output logic                               m_tlast,
  input  wire crp_pkg::dp_cmd_t              cmd,
  output crp_pkg::dp_status_t                status
);
  import crp_pkg::*;

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  // Collection state.
  logic [CW-1:0]    held_count;
  logic [ACC_W-1:0] rows_acc;
  logic [ACC_W-1:0] cols_acc;
  logic [1:0]       seen_separator;

  // Flush state.
  logic [CW-1:0] flush_len;
  logic [AW-1:0] flush_idx;

  // Output register payload.
  kind_t            out_kind;
  logic [7:0]       out_key;
  logic [ACC_W-1:0] out_rows;
  logic [ACC_W-1:0] out_cols;
  logic             out_last;

  logic [7:0]    ram_rdata;
  logic [CW-1:0] pos;
  logic          is_digit;
  logic          fits;
  logic          ev_direct;
  logic          ev_store;
  logic          ev_flush;
  logic          ev_report;
  logic          ev_tflush;
  logic          ev_acc;
  logic          report_ok;
  logic [3:0]    digit;
  logic [ACC_W-1:0] acc_sel;
  logic [ACC_W-1:0] acc_new;
  logic          load_direct;

  // Multiply by ten, add the digit and clamp at the top of the range.
  function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [ACC_W+3:0] v;
    v = {acc, 3'b000} + {3'b000, acc, 1'b0} + {{ACC_W{1'b0}}, d};
    acc_digit = (v > {4'b0000, {ACC_W{1'b1}}}) ? {ACC_W{1'b1}} : v[ACC_W-1:0];
  endfunction

  // Classify the offered byte against the pattern.
  always_comb begin
    pos       = held_count + CW'(1);
    is_digit  = (s_tdata >= BYTE_ZERO) && (s_tdata <= BYTE_NINE);
    if (pos == CW'(1)) begin
      fits = 1'b1;
    end else if (pos == CW'(2)) begin
      fits = (s_tdata == BYTE_LBRACKET);
    end else begin
      fits = is_digit || (s_tdata == BYTE_SEMI) || (s_tdata == BYTE_R);
    end
    ev_direct = (s_tuser == CMD_BYTE) && (held_count == '0) && (s_tdata != BYTE_ESC);
    ev_store  = (s_tuser == CMD_BYTE) && !ev_direct;
    ev_flush  = ev_store && (!fits || (pos >= CW'(HOLD_DEPTH)));
    ev_report = ev_store && !ev_flush && (s_tdata == BYTE_R);
    ev_tflush = (s_tuser == CMD_TIMEOUT) && (held_count != '0);
    ev_acc    = ev_store && !ev_flush && !ev_report && (pos > CW'(2));
    report_ok = (rows_acc != '0) && (cols_acc != '0) && (seen_separator == 2'd1);
    digit     = s_tdata[3:0];
    acc_sel   = (seen_separator == 2'd0) ? rows_acc : cols_acc;
    acc_new   = acc_digit(acc_sel, digit);
    load_direct = cmd.take && (ev_direct || ev_report);
  end

  // Status toward the controller.
  always_comb begin
    status.out_free   = !m_tvalid || m_tready;
    status.flush_go   = ev_flush || ev_tflush;
    status.flush_last = ({{(CW-AW){1'b0}}, flush_idx} == (flush_len - CW'(1)));
  end

  // Hold buffer: every stored byte goes in at the current count.
  crp_ram #(
    .WIDTH(8),
    .DEPTH(HOLD_DEPTH)
  ) u_hold (
    .clk  (clk),
    .we   (cmd.take && ev_store),
    .waddr(held_count[AW-1:0]),
    .wdata(s_tdata),
    .re   (cmd.rd_issue),
    .raddr(flush_idx),
    .rdata(ram_rdata)
  );

  // Collection registers and flush bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count     <= '0;
      rows_acc       <= '0;
      cols_acc       <= '0;
      seen_separator <= 2'd0;
      flush_idx      <= '0;
      flush_len      <= '0;
    end else begin
      if (cmd.take) begin
        if ((s_tuser == CMD_TIMEOUT) || ev_flush || ev_report) begin
          held_count     <= '0;
          rows_acc       <= '0;
          cols_acc       <= '0;
          seen_separator <= 2'd0;
          flush_idx      <= '0;
          flush_len      <= (s_tuser == CMD_TIMEOUT) ? held_count : pos;
        end else if (ev_store) begin
          held_count <= pos;
          if (ev_acc) begin
            if (s_tdata == BYTE_SEMI) begin
              if (seen_separator != 2'd2) begin
                seen_separator <= seen_separator + 2'd1;
              end
            end else if (is_digit) begin
              if (seen_separator == 2'd0) begin
                rows_acc <= acc_new;
              end else begin
                cols_acc <= acc_new;
              end
            end
          end
        end
      end
      if (cmd.send) begin
        flush_idx <= flush_idx + AW'(1);
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_direct || cmd.send) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (cmd.send) begin
      out_kind <= KIND_KEY;
      out_key  <= ram_rdata;
      out_rows <= '0;
      out_cols <= '0;
      out_last <= status.flush_last;
    end else if (load_direct) begin
      out_last <= 1'b1;
      if (ev_direct) begin
        out_kind <= KIND_KEY;
        out_key  <= s_tdata;
        out_rows <= '0;
        out_cols <= '0;
      end else if (report_ok) begin
        out_kind <= KIND_REPORT;
        out_key  <= '0;
        out_rows <= rows_acc;
        out_cols <= cols_acc;
      end else begin
        out_kind <= KIND_REJECT;
        out_key  <= '0;
        out_rows <= '0;
        out_cols <= '0;
      end
    end
  end

  assign m_tdata = {out_cols, out_rows, out_key};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule
`default_nettype wire

// File: tb/cursor_report_parser_tb.sv
`timescale 1ns / 100ps
module cursor_report_parser_tb;
  import crp_pkg::*;

  localparam int HOLD = HOLD_DEPTH_DEF;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 2 * HOLD + 8;
  localparam int DRAIN_LIMIT = 50000;

  // One result beat as the block should present it.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  key;
    logic [15:0] rows;
    logic [15:0] cols;
    logic        last;
  } crp_result_t;

  // Ways the receiver applies backpressure.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN,
    READY_SPARSE
  } ready_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // in_byte[7:0]
  logic                  s_tuser = 1'b0; // cmd[0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // key_byte[7:0], report_rows[23:8],
                                         // report_cols[39:24]
  logic [1:0]            m_tuser;        // kind[1:0]
  logic                  m_tlast;

  // Shadow of the parser state.
  logic [7:0]  held_buf [HOLD];
  int          held_len = 0;
  int          row_count = 0;
  int          col_count = 0;
  int          semi_count = 0;
  crp_result_t parsed_results_q[$];

  // Stimulus and receiver controls.
  int          gap_max = 0;
  int          burst_left = 0;
  int          beats_sent = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  logic [7:0]  stall_phase = '0;

  // Checker bookkeeping.
  int          fail_count = 0;
  int          keys_seen = 0;
  int          reports_seen = 0;
  int          rejects_seen = 0;
  crp_result_t head_result;

  cursor_report_parser #(
    .HOLD_DEPTH(HOLD)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  // Queue one expected result beat.
  task automatic push_result(input kind_t kind, input logic [7:0] key,
                             input logic [15:0] rows, input logic [15:0] cols,
                             input logic last);
    crp_result_t r;
    r.kind = kind;
    r.key  = key;
    r.rows = rows;
    r.cols = cols;
    r.last = last;
    parsed_results_q.push_back(r);
  endtask

  // Every held byte leaves as a key, oldest first, and collection restarts.
  task automatic flush_held_keys();
    for (int i = 0; i < held_len; i++) begin
      push_result(KIND_KEY, held_buf[i], '0, '0, i == held_len - 1);
    end
    held_len = 0;
    row_count = 0;
    col_count = 0;
    semi_count = 0;
  endtask

  function automatic int add_digit(input int acc, input logic [7:0] b);
    int v;
    v = acc * 10 + int'(b - BYTE_ZERO);
    return (v > 65535) ? 65535 : v;
  endfunction

  // Work out the results caused by one accepted input beat.
  task automatic parse_terminal_byte(input logic cmd, input logic [7:0] b);
    logic is_digit;
    logic fits;
    int   pos;
    if (cmd == CMD_TIMEOUT) begin
      flush_held_keys();
      return;
    end
    if (held_len == 0 && b != BYTE_ESC) begin
      push_result(KIND_KEY, b, '0, '0, 1'b1);
      return;
    end
    held_buf[held_len] = b;
    held_len++;
    pos = held_len;
    is_digit = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
    if (pos == 1) begin
      fits = 1'b1;
    end else if (pos == 2) begin
      fits = (b == BYTE_LBRACKET);
    end else begin
      fits = is_digit || b == BYTE_SEMI || b == BYTE_R;
    end
    // A breaking byte or a full buffer sends everything out as keys.
    if (!fits || pos >= HOLD) begin
      flush_held_keys();
      return;
    end
    if (b == BYTE_R) begin
      if (row_count != 0 && col_count != 0 && semi_count == 1) begin
        push_result(KIND_REPORT, '0, 16'(row_count), 16'(col_count), 1'b1);
      end else begin
        push_result(KIND_REJECT, '0, '0, '0, 1'b1);
      end
      held_len = 0;
      row_count = 0;
      col_count = 0;
      semi_count = 0;
      return;
    end
    if (pos > 2) begin
      if (b == BYTE_SEMI) begin
        if (semi_count < 2) semi_count++;
      end else if (is_digit) begin
        if (semi_count == 0) row_count = add_digit(row_count, b);
        else col_count = add_digit(col_count, b);
      end
    end
  endtask

  // Offer one beat in bursts with random gaps; return once it is accepted.
  task automatic send_beat(input logic cmd, input logic [7:0] b);
    logic ignored;
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= cmd;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    ignored = (cmd == CMD_TIMEOUT) && (held_len == 0);
    parse_terminal_byte(cmd, b);
    if (!ignored) beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(CMD_BYTE, s[i]);
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) begin
      send_beat(CMD_BYTE, BYTE_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // Mostly short numbers, sometimes none, sometimes long enough to saturate.
  function automatic int digit_count();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(6, 9);
    return $urandom_range(1, 4);
  endfunction

  // Receiver: long hold-offs on request, otherwise the current stall pattern.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      m_tready <= 1'b0;
      hold_left <= LONG_HOLD_CYCLES - 1;
      hold_served <= hold_served + 1;
    end else begin
      case (ready_mode)
        READY_ALWAYS: begin
          m_tready <= 1'b1;
        end
        READY_RANDOM: begin
          m_tready <= ($urandom_range(0, 99) >= 30);
        end
        READY_PATTERN: begin
          m_tready <= (stall_phase % 7) < 4;
        end
        default: begin
          m_tready <= ($urandom_range(0, 99) >= 70);
        end
      endcase
    end
  end

  // Compare every result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (parsed_results_q.size() == 0) begin
        $error("result beat with nothing expected: kind %0d data %h", m_tuser, m_tdata);
        fail_count++;
      end else begin
        head_result = parsed_results_q.pop_front();
        if (m_tuser !== head_result.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", head_result.kind, m_tuser);
          fail_count++;
        end
        if (m_tdata[7:0] !== head_result.key) begin
          $error("key_byte mismatch: expected %h, actual %h", head_result.key,
                 m_tdata[7:0]);
          fail_count++;
        end
        if (m_tdata[23:8] !== head_result.rows) begin
          $error("report_rows mismatch: expected %0d, actual %0d", head_result.rows,
                 m_tdata[23:8]);
          fail_count++;
        end
        if (m_tdata[39:24] !== head_result.cols) begin
          $error("report_cols mismatch: expected %0d, actual %0d", head_result.cols,
                 m_tdata[39:24]);
          fail_count++;
        end
        if (m_tlast !== head_result.last) begin
          $error("last mismatch: expected %0d, actual %0d", head_result.last, m_tlast);
          fail_count++;
        end
        case (head_result.kind)
          KIND_KEY:    keys_seen++;
          KIND_REPORT: reports_seen++;
          default:     rejects_seen++;
        endcase
      end
    end
  end

  // Ordinary bytes with nothing held pass straight through.
  task automatic test_plain_keys();
    send_beat(CMD_BYTE, 8'h00);
    send_beat(CMD_BYTE, 8'hff);
    send_text("A[R0;");
  endtask

  task automatic test_valid_report();
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[24;80R");
  endtask

  // Zero rows, zero columns, no separator, and a second separator.
  task automatic test_rejected_reports();
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[;5R");
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[5;R");
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[5R");
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[1;2;3R");
  endtask

  // Wrong second byte, a letter mid-report, and an ESC that breaks a report.
  task automatic test_pattern_breaks();
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("R");
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[1A");
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[2");
    send_beat(CMD_BYTE, BYTE_ESC);
    send_beat(CMD_BYTE, BYTE_ESC);
    send_beat(CMD_BYTE, BYTE_ESC);
  endtask

  task automatic test_saturation();
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[99999;070000R");
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[65535;1R");
  endtask

  // Filling the buffer flushes it, even when the closing byte is 'R'.
  task automatic test_hold_buffer_full();
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[1;23456789012R");
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[98765432109876");
  endtask

  // Timeout with nothing held, then one that cuts a report short.
  task automatic test_timeouts();
    send_beat(CMD_TIMEOUT, 8'ha5);
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[3;");
    send_beat(CMD_TIMEOUT, 8'h5a);
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[1;1R");
  endtask

  // Random traffic: mostly well-formed reports, plus broken ones and noise.
  task automatic test_random_traffic(input int n_beats, input int gaps,
                                     input ready_mode_t mode);
    int start;
    int r;
    gap_max = gaps;
    ready_mode <= mode;
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_beat(CMD_BYTE, BYTE_ESC);
        send_beat(CMD_BYTE, BYTE_LBRACKET);
        send_digits(digit_count());
        send_beat(CMD_BYTE, BYTE_SEMI);
        if ($urandom_range(0, 9) == 0) begin
          send_digits(digit_count());
          send_beat(CMD_BYTE, BYTE_SEMI);
        end
        send_digits(digit_count());
        send_beat(CMD_BYTE, BYTE_R);
      end else if (r < 60) begin
        send_beat(CMD_BYTE, BYTE_ESC);
        if ($urandom_range(0, 3) != 0) begin
          send_beat(CMD_BYTE, BYTE_LBRACKET);
          send_digits($urandom_range(0, 3));
        end
        send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
      end else if (r < 70) begin
        send_beat(CMD_BYTE, BYTE_ESC);
        send_beat(CMD_BYTE, BYTE_LBRACKET);
        send_digits($urandom_range(0, 4));
        send_beat(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
      end else if (r < 92) begin
        send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send_beat(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    gap_max = 0;
    ready_mode <= READY_ALWAYS;
    hold_requests <= hold_requests + 1;
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[12;34R");
    send_beat(CMD_BYTE, BYTE_ESC);
    send_text("[7x");
    test_random_traffic(40, 0, READY_RANDOM);
    hold_requests <= hold_requests + 1;
    test_random_traffic(40, 0, READY_PATTERN);
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_keys();
    test_valid_report();
    test_rejected_reports();
    test_pattern_breaks();
    test_saturation();
    test_hold_buffer_full();
    test_timeouts();
    test_backpressure();
    test_random_traffic(50, 0, READY_ALWAYS);
    test_random_traffic(50, 4, READY_RANDOM);
    test_random_traffic(50, 0, READY_PATTERN);
    test_random_traffic(50, 8, READY_SPARSE);
    test_random_traffic(50, 2, READY_RANDOM);

    // Let the remaining results drain, then allow for a trailing flush.
    s_tvalid <= 1'b0;
    ready_mode <= READY_RANDOM;
    waited = 0;
    while (parsed_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (parsed_results_q.size() != 0) begin
      $error("%0d expected results never arrived", parsed_results_q.size());
      fail_count++;
    end

    $display("Sent %0d input beats across directed and random phases with stalls.",
             beats_sent);
    $display("Checked %0d keys, %0d size reports and %0d rejected reports.",
             keys_seen, reports_seen, rejects_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog in case the handshakes hang.
  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/crp_pkg.sv
design/crp_ram.sv
design/crp_ctrl.sv
design/crp_datapath.sv
design/cursor_report_parser.sv
tb/cursor_report_parser_tb.sv
